/* sv/nalm_pkg.sv */
// Shared types, codes and keyword tables for the acknowledgement line matcher.
package nalm_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAIT    = 2'd1,
        PH_ACK     = 2'd2,
        PH_TIMEOUT = 2'd3
    } t_phase;

    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int NUM_KW = 4;
    localparam int KW_MAX = 4;

    typedef logic [2:0] t_prog;
    typedef t_prog [NUM_KW-1:0] t_kw_prog;

    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
        '{8'h50, 8'h4C, 8'h53, 8'h43},
        '{8'h50, 8'h41, 8'h49, 8'h52},
        '{8'h4F, 8'h4B, 8'h00, 8'h00},
        '{8'h41, 8'h43, 8'h4B, 8'h00}
    };

    localparam t_prog KW_LEN [NUM_KW] = '{3'd4, 3'd4, 3'd2, 3'd3};

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

endpackage

/* sv/nalm_kw_match.sv */
// Per-keyword match progress update for one received character.
module nalm_kw_match
    import nalm_pkg::*;
(
    input  t_kw_prog   i_progress,
    input  logic [7:0] i_char,
    output t_kw_prog   o_progress,
    output logic       o_hit
);

    always_comb begin
        t_prog p;
        p = '0;
        o_hit = 1'b0;
        o_progress = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            p = i_progress[k];
            if (p >= KW_LEN[k]) begin
                p = '0;
            end
            if (i_char == KW_TEXT[k][p[1:0]]) begin
                p = p + 3'd1;
            end else if (i_char == KW_TEXT[k][0]) begin
                p = 3'd1;
            end else begin
                p = 3'd0;
            end
            if (p >= KW_LEN[k]) begin
                o_hit = 1'b1;
                p = '0;
            end
            o_progress[k] = p;
        end
    end

endmodule

/* sv/nmea_ack_line_matcher.sv */
// Top level of the acknowledgement line matcher with its state and result register.
// Each accepted beat gives one result beat in the following cycle, from a single result register.
// A new input beat is accepted every cycle while the result register is empty or being taken.
// Keyword search, line length and tick count are updated in that same cycle.
// Synchronous active-low reset returns the block to idle with a timeout of 1000 ticks.
module nmea_ack_line_matcher
    import nalm_pkg::*;
#(
    parameter int LINE_LIMIT = 128
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_line_closed,
    output logic        o_line_matched,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_timeout_ticks
);

    localparam int LEN_W = $clog2(LINE_LIMIT);
    localparam logic [LEN_W-1:0] LAST_LEN = LEN_W'(LINE_LIMIT - 1);

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    t_kw_prog         r_prog, n_prog;
    logic             r_seen, n_seen;
    logic [15:0]      r_elapsed, n_elapsed;
    logic [15:0]      r_timeout;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic             r_closed, n_closed;
    logic             r_matched, n_matched;

    t_kw_prog         kw_next;
    logic             kw_hit;
    logic             in_acc;

    nalm_kw_match u_kw_match (
        .i_progress (r_prog),
        .i_char     (i_data_byte),
        .o_progress (kw_next),
        .o_hit      (kw_hit)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_prog    = r_prog;
        n_seen    = r_seen;
        n_elapsed = r_elapsed;
        n_closed  = 1'b0;
        n_matched = 1'b0;
        case (i_operation)
            OP_ARM: begin
                n_len     = '0;
                n_prog    = '0;
                n_seen    = 1'b0;
                n_elapsed = '0;
                n_phase   = (r_timeout == '0) ? PH_TIMEOUT : PH_WAIT;
            end
            OP_BYTE: begin
                if (r_phase == PH_WAIT) begin
                    if (r_len == '0) begin
                        if (i_data_byte == CH_DOLLAR) begin
                            n_prog = '0;
                            n_seen = 1'b0;
                            n_len  = LEN_W'(1);
                        end
                    end else if (r_len < LAST_LEN) begin
                        n_len  = r_len + LEN_W'(1);
                        n_prog = kw_next;
                        n_seen = r_seen | kw_hit;
                        if (i_data_byte == CH_LF || i_data_byte == CH_CR) begin
                            n_closed = 1'b1;
                            if (r_seen || kw_hit) begin
                                n_matched = 1'b1;
                                n_phase   = PH_ACK;
                            end
                            n_len  = '0;
                            n_prog = '0;
                            n_seen = 1'b0;
                        end
                    end else begin
                        n_len  = '0;
                        n_prog = '0;
                        n_seen = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_WAIT) begin
                    if (r_elapsed != TICKS_MAX) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                    if (n_elapsed >= r_timeout) begin
                        n_phase = PH_TIMEOUT;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_len       <= '0;
            r_prog      <= '0;
            r_seen      <= 1'b0;
            r_elapsed   <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_timeout_ticks;
            end
            if (in_acc) begin
                r_phase     <= n_phase;
                r_len       <= n_len;
                r_prog      <= n_prog;
                r_seen      <= n_seen;
                r_elapsed   <= n_elapsed;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status  <= n_phase;
            r_closed  <= n_closed;
            r_matched <= n_matched;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_line_closed  = r_closed;
    assign o_line_matched = r_matched;

`ifndef SYNTH
    a_match_needs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_matched) |-> (o_line_closed && o_status == PH_ACK))
        else $error("Matched line reported without a close or acknowledged status.");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LAST_LEN)
        else $error("Line length beyond the line limit.");

    a_arm_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_ARM)
        |=> (o_out_valid && (o_status == PH_WAIT || o_status == PH_TIMEOUT)))
        else $error("Arm beat did not report waiting or timed out.");

    a_idle_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) |-> (r_prog == '0 && !r_seen))
        else $error("Keyword state left behind with no line open.");
`endif

endmodule
